>>> rtl/flca_pkg.sv
// Package for the fully associative LRU block cache: shared types and codes.
`timescale 1ns / 1ps
`default_nettype none
package flca_pkg;

	localparam int DRUM_W   = 4;
	localparam int BLOCK_W  = 8;
	localparam int HANDLE_W = 16;
	localparam int CFG_W    = 7;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	typedef struct packed {
		logic [DRUM_W-1:0]  drum;
		logic [BLOCK_W-1:0] block;
	} tag_t;

	// Broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic clear;   // invalidate, ranks back to index order
		logic cmp;     // capture tag match and victim candidate
		logic upd;     // apply recency update and fill
		logic hit;     // some cell matched
		logic insert;  // request is an insert
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

endpackage
`default_nettype wire

>>> rtl/flca_if.sv
// Request and response channel interfaces of the block cache.
`timescale 1ns / 1ps
`default_nettype none
interface flca_req_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [flca_pkg::DRUM_W-1:0]   drum;
	logic [flca_pkg::BLOCK_W-1:0]  block;
	logic [flca_pkg::HANDLE_W-1:0] line_handle;

	modport source(output valid, func, drum, block, line_handle, input ready);
	modport sink(input valid, func, drum, block, line_handle, output ready);
endinterface

interface flca_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [flca_pkg::HANDLE_W-1:0] hit_handle;
	logic                          evicted;
	logic [flca_pkg::DRUM_W-1:0]   evicted_drum;
	logic [flca_pkg::BLOCK_W-1:0]  evicted_block;
	logic [flca_pkg::HANDLE_W-1:0] evicted_handle;

	modport source(output valid, hit, hit_handle, evicted, evicted_drum, evicted_block,
		evicted_handle, input ready);
	modport sink(input valid, hit, hit_handle, evicted, evicted_drum, evicted_block,
		evicted_handle, output ready);
endinterface
`default_nettype wire

>>> rtl/fully_assoc_lru_block_cache.sv
// Top level of the fully associative LRU block cache.
//
// Requests arrive on req (func, drum, block, line_handle); one response per
// request leaves on rsp (hit, hit_handle, evicted and the evicted tag/handle).
// A lookup or insert whose tag is present returns the stored handle and makes
// the entry most recent. An insert miss fills the next unused entry, or once
// all entries in use are full, replaces the least recent one and reports it.
// Each request passes a compare state, for the tag compare broadcast to the cell
// row, and an update state, for the recency update and fill across the row. A
// new request is taken in the update cycle, so back-to-back requests overlap,
// and the response is registered as the update cycle completes.
// A response register sits on rsp; if the receiver stalls with a response
// waiting, the request in the update cycle holds there until the slot frees.
// cfg_we/cfg_wdata sets the number of entries in use (0 acts as 1, values
// above MAX_LINES saturate) and invalidates every entry; write only when idle.
// After reset all entries are invalid, ranks follow index order and the
// entry count is 64, saturated to MAX_LINES.
`timescale 1ns / 1ps
`default_nettype none
module fully_assoc_lru_block_cache #(
	parameter int MAX_LINES   = 64,
	parameter int HANDLE_BITS = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [flca_pkg::CFG_W-1:0]     cfg_wdata,
	flca_req_if.sink                      req,
	flca_rsp_if.source                    rsp
);

	localparam int CW = $clog2(MAX_LINES + 1);
	localparam int RW = $clog2(MAX_LINES);
	localparam int RESET_LINES = (64 > MAX_LINES) ? MAX_LINES : 64;

	flca_pkg::state_t state_q, state_d;

	logic                   func_q;
	flca_pkg::tag_t         key_q;
	logic [HANDLE_BITS-1:0] handle_in_q;
	logic [CW-1:0]          n_lines_q;
	logic [CW-1:0]          fill_q;

	logic                   rsp_valid_q;
	logic                   hit_q;
	logic [flca_pkg::HANDLE_W-1:0] hit_handle_q;
	logic                   evicted_q;
	flca_pkg::tag_t         ev_tag_q;
	logic [flca_pkg::HANDLE_W-1:0] ev_handle_q;

	logic slot_free;
	logic req_fire;
	logic in_ready;
	logic cmp_en;
	logic done;

	logic [MAX_LINES-1:0]   match_v;
	logic [MAX_LINES-1:0]   cand_v;
	flca_pkg::tag_t         tag_a    [MAX_LINES];
	logic [HANDLE_BITS-1:0] handle_a [MAX_LINES];
	logic [RW-1:0]          rank_a   [MAX_LINES];

	logic                   hit_any;
	logic                   is_insert;
	logic                   do_evict;
	logic [RW-1:0]          touch_rank;
	logic [HANDLE_BITS-1:0] hit_handle_or;
	flca_pkg::tag_t         ev_tag_or;
	logic [HANDLE_BITS-1:0] ev_handle_or;
	logic [CW-1:0]          cfg_lines;
	logic [31:0]            cfg_v32;

	flca_pkg::cell_ctl_t    ctl;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && in_ready;
	assign is_insert = (func_q == flca_pkg::FUNC_INSERT);
	assign do_evict  = !hit_any && is_insert && (fill_q == n_lines_q);

	// Saturate the written entry count into 1..MAX_LINES.
	assign cfg_v32 = 32'(cfg_wdata);
	always_comb begin
		if (cfg_v32 == 32'd0) begin
			cfg_lines = CW'(1);
		end else if (cfg_v32 > 32'(MAX_LINES)) begin
			cfg_lines = CW'(MAX_LINES);
		end else begin
			cfg_lines = CW'(cfg_v32);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			flca_pkg::ST_IDLE: begin
				if (req.valid) state_d = flca_pkg::ST_CMP;
			end
			flca_pkg::ST_CMP: begin
				state_d = flca_pkg::ST_UPD;
			end
			flca_pkg::ST_UPD: begin
				if (slot_free) state_d = req.valid ? flca_pkg::ST_CMP : flca_pkg::ST_IDLE;
			end
			default: begin
				state_d = flca_pkg::ST_IDLE;
			end
		endcase
	end

	// FSM outputs.
	always_comb begin
		in_ready = 1'b0;
		cmp_en   = 1'b0;
		done     = 1'b0;
		case (state_q)
			flca_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			flca_pkg::ST_CMP: begin
				cmp_en = 1'b1;
			end
			flca_pkg::ST_UPD: begin
				done     = slot_free;
				in_ready = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flca_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			func_q      <= req.func;
			key_q.drum  <= req.drum;
			key_q.block <= req.block;
			handle_in_q <= HANDLE_BITS'(req.line_handle);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_lines_q <= CW'(RESET_LINES);
			fill_q    <= '0;
		end else if (cfg_we) begin
			n_lines_q <= cfg_lines;
			fill_q    <= '0;
		end else if (done && !hit_any && is_insert && (fill_q < n_lines_q)) begin
			fill_q <= fill_q + CW'(1);
		end
	end

	// Collect the flagged cells' fields; at most one cell is flagged per field.
	always_comb begin
		hit_any       = 1'b0;
		touch_rank    = '0;
		hit_handle_or = '0;
		ev_tag_or     = '0;
		ev_handle_or  = '0;
		for (int i = 0; i < MAX_LINES; i++) begin
			hit_any       = hit_any | match_v[i];
			hit_handle_or = hit_handle_or | (match_v[i] ? handle_a[i] : '0);
			ev_tag_or     = ev_tag_or | (cand_v[i] ? tag_a[i] : '0);
			ev_handle_or  = ev_handle_or | (cand_v[i] ? handle_a[i] : '0);
		end
		for (int i = 0; i < MAX_LINES; i++) begin
			if (hit_any ? match_v[i] : cand_v[i]) touch_rank = touch_rank | rank_a[i];
		end
	end

	always_comb begin
		ctl.clear  = cfg_we;
		ctl.cmp    = cmp_en;
		ctl.upd    = done;
		ctl.hit    = hit_any;
		ctl.insert = is_insert;
	end

	for (genvar g = 0; g < MAX_LINES; g++) begin : g_cell
		flca_cell #(
			.IDX         (g),
			.MAX_LINES   (MAX_LINES),
			.HANDLE_BITS (HANDLE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key_q),
			.new_handle (handle_in_q),
			.n_lines    (n_lines_q),
			.fill_cnt   (fill_q),
			.touch_rank (touch_rank),
			.match_q    (match_v[g]),
			.cand_q     (cand_v[g]),
			.tag_q      (tag_a[g]),
			.handle_q   (handle_a[g]),
			.rank_q     (rank_a[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			hit_q        <= hit_any;
			hit_handle_q <= hit_any ? flca_pkg::HANDLE_W'(hit_handle_or) : '0;
			evicted_q    <= do_evict;
			ev_tag_q     <= do_evict ? ev_tag_or : '0;
			ev_handle_q  <= do_evict ? flca_pkg::HANDLE_W'(ev_handle_or) : '0;
		end
	end

	assign req.ready          = in_ready;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.hit            = hit_q;
	assign rsp.hit_handle     = hit_handle_q;
	assign rsp.evicted        = evicted_q;
	assign rsp.evicted_drum   = ev_tag_q.drum;
	assign rsp.evicted_block  = ev_tag_q.block;
	assign rsp.evicted_handle = ev_handle_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= n_lines_q)
		else $error("fill count exceeds entries in use");

	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == flca_pkg::ST_UPD) |-> $onehot0(match_v))
		else $error("tag matched in more than one entry");

	a_one_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == flca_pkg::ST_UPD && is_insert && !hit_any) |-> $onehot(cand_v))
		else $error("insert miss without exactly one victim");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(hit_q && evicted_q))
		else $error("response reports both hit and eviction");

	a_done_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> rsp_valid_q)
		else $error("completed request produced no response");

endmodule
`default_nettype wire

>>> rtl/flca_cell.sv
// One cache entry: tag, handle, recency rank and per-request match/victim flags.
`timescale 1ns / 1ps
`default_nettype none
module flca_cell #(
	parameter int IDX         = 0,
	parameter int MAX_LINES   = 64,
	parameter int HANDLE_BITS = 16,
	localparam int CW = $clog2(MAX_LINES + 1),
	localparam int RW = $clog2(MAX_LINES)
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  flca_pkg::cell_ctl_t       ctl,
	input  flca_pkg::tag_t            key,
	input  wire [HANDLE_BITS-1:0]     new_handle,
	input  wire [CW-1:0]              n_lines,
	input  wire [CW-1:0]              fill_cnt,
	input  wire [RW-1:0]              touch_rank,
	output logic                      match_q,
	output logic                      cand_q,
	output flca_pkg::tag_t            tag_q,
	output logic [HANDLE_BITS-1:0]    handle_q,
	output logic [RW-1:0]             rank_q
);

	logic entry_valid;
	logic in_use;
	logic is_lru;
	logic sel;
	logic [CW-1:0] last_rank;

	// Entries fill strictly in index order, so the fill count gives validity.
	assign entry_valid = CW'(IDX) < fill_cnt;
	assign in_use      = CW'(IDX) < n_lines;
	assign last_rank   = n_lines - CW'(1);
	assign is_lru      = in_use && (rank_q == RW'(last_rank));
	assign sel         = ctl.hit ? match_q : (ctl.insert && cand_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			cand_q  <= 1'b0;
			rank_q  <= RW'(IDX);
		end else if (ctl.clear) begin
			match_q <= 1'b0;
			cand_q  <= 1'b0;
			rank_q  <= RW'(IDX);
		end else begin
			if (ctl.cmp) begin
				match_q <= entry_valid && (tag_q == key);
				if (fill_cnt < n_lines) begin
					cand_q <= (fill_cnt == CW'(IDX));
				end else begin
					cand_q <= is_lru;
				end
			end
			if (ctl.upd && (ctl.hit || ctl.insert)) begin
				if (sel) begin
					rank_q <= '0;
				end else if (in_use && (rank_q < touch_rank)) begin
					rank_q <= rank_q + RW'(1);
				end
			end
		end
	end

	// Payload: written on an insert miss into the chosen entry.
	always_ff @(posedge clk) begin
		if (ctl.upd && !ctl.hit && ctl.insert && cand_q) begin
			tag_q    <= key;
			handle_q <= new_handle;
		end
	end

endmodule
`default_nettype wire

>>> sim/tb_fully_assoc_lru_block_cache.sv
// Self-checking testbench for the fully associative LRU block cache.
`timescale 1ns / 1ps
module tb_fully_assoc_lru_block_cache;

	localparam int LINES_MAX = 64;

	typedef struct packed {
		logic                          func;
		flca_pkg::tag_t                tag;
		logic [flca_pkg::HANDLE_W-1:0] handle;
	} access_t;

	typedef struct packed {
		logic                          hit;
		logic [flca_pkg::HANDLE_W-1:0] hit_handle;
		logic                          evicted;
		flca_pkg::tag_t                ev_tag;
		logic [flca_pkg::HANDLE_W-1:0] ev_handle;
	} outcome_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [flca_pkg::CFG_W-1:0] cfg_wdata;

	flca_req_if req_ch();
	flca_rsp_if rsp_ch();

	fully_assoc_lru_block_cache DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Cache image kept alongside the block
	logic                          ent_valid  [LINES_MAX];
	flca_pkg::tag_t                ent_tag    [LINES_MAX];
	logic [flca_pkg::HANDLE_W-1:0] ent_handle [LINES_MAX];
	int                            ent_rank   [LINES_MAX];
	int                            lines_active;

	outcome_t pending_outcomes[$];
	int       errors;
	logic     src_calm;
	logic     sink_calm;
	int       sink_hold;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("TEST FAILED");
		$finish;
	end

	function automatic void clear_image(input logic [flca_pkg::CFG_W-1:0] count);
		int i;
		if (count == 0)
			lines_active = 1;
		else if (count > LINES_MAX)
			lines_active = LINES_MAX;
		else
			lines_active = int'(count);
		for (i = 0; i < LINES_MAX; i++) begin
			ent_valid[i]  = 1'b0;
			ent_tag[i]    = '0;
			ent_handle[i] = '0;
			ent_rank[i]   = i;
		end
	endfunction

	// Move entry to rank 0, everything more recent than it ages by one.
	function automatic void promote(input int e);
		int i;
		int r;
		r = ent_rank[e];
		for (i = 0; i < lines_active; i++)
			if (ent_rank[i] < r)
				ent_rank[i]++;
		ent_rank[e] = 0;
	endfunction

	function automatic outcome_t predict_outcome(input access_t a);
		outcome_t o;
		int       i;
		int       slot;
		o = '0;
		slot = -1;
		for (i = 0; i < lines_active; i++)
			if (slot < 0 && ent_valid[i] && ent_tag[i] == a.tag)
				slot = i;
		if (slot >= 0) begin
			o.hit        = 1'b1;
			o.hit_handle = ent_handle[slot];
			promote(slot);
			return o;
		end
		if (a.func == flca_pkg::FUNC_LOOKUP)
			return o;
		for (i = 0; i < lines_active; i++)
			if (slot < 0 && !ent_valid[i])
				slot = i;
		if (slot < 0) begin
			slot = 0;
			for (i = 1; i < lines_active; i++)
				if (ent_rank[i] > ent_rank[slot])
					slot = i;
			o.evicted   = 1'b1;
			o.ev_tag    = ent_tag[slot];
			o.ev_handle = ent_handle[slot];
		end
		ent_valid[slot]  = 1'b1;
		ent_tag[slot]    = a.tag;
		ent_handle[slot] = a.handle;
		promote(slot);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// Called at a clock edge; returns at the edge where the transaction is taken, or after the gap that follows it.
	// valid stays high on return unless a gap was inserted.
	task automatic send_request(input access_t a);
		req_ch.valid       <= 1'b1;
		req_ch.func        <= a.func;
		req_ch.drum        <= a.tag.drum;
		req_ch.block       <= a.tag.block;
		req_ch.line_handle <= a.handle;
		do @(posedge clk); while (!req_ch.ready);
		pending_outcomes.push_back(predict_outcome(a));
		if (!src_calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic send_fields(input logic func, input int drum, input int block, input int handle);
		access_t a;
		a.func       = func;
		a.tag.drum   = flca_pkg::DRUM_W'(drum);
		a.tag.block  = flca_pkg::BLOCK_W'(block);
		a.handle     = flca_pkg::HANDLE_W'(handle);
		send_request(a);
	endtask

	task automatic drop_valid();
		req_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Only while idle: the write wipes every entry.
	task automatic write_lines(input logic [flca_pkg::CFG_W-1:0] count);
		cfg_wdata <= count;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		clear_image(count);
	endtask

	task automatic run_traffic(input logic [flca_pkg::CFG_W-1:0] count, input int n,
		input int insert_pct);
		flca_pkg::tag_t pool [80];
		int             pool_n;
		int             k;
		access_t        a;
		drop_valid();
		wait_drained();
		write_lines(count);
		pool_n = lines_active + 3;
		for (k = 0; k < pool_n; k++) begin
			pool[k].drum  = flca_pkg::DRUM_W'($urandom_range(0, 15));
			pool[k].block = flca_pkg::BLOCK_W'($urandom_range(0, 255));
		end
		repeat (n) begin
			a.func = ($urandom_range(0, 99) < insert_pct) ? flca_pkg::FUNC_INSERT
				: flca_pkg::FUNC_LOOKUP;
			if ($urandom_range(0, 9) == 0) begin
				a.tag.drum  = flca_pkg::DRUM_W'($urandom_range(0, 15));
				a.tag.block = flca_pkg::BLOCK_W'($urandom_range(0, 255));
			end else begin
				a.tag = pool[$urandom_range(0, pool_n - 1)];
			end
			a.handle = flca_pkg::HANDLE_W'($urandom_range(0, 65535));
			send_request(a);
		end
	endtask

	// Entry count left at its reset value
	task automatic test_reset_defaults();
		send_fields(flca_pkg::FUNC_LOOKUP, 0, 0, 16'hffff);
		send_fields(flca_pkg::FUNC_INSERT, 0, 0, 16'h0000);
		send_fields(flca_pkg::FUNC_INSERT, 15, 255, 16'hffff);
		send_fields(flca_pkg::FUNC_LOOKUP, 15, 255, 0);
		send_fields(flca_pkg::FUNC_LOOKUP, 0, 0, 16'h5a5a);
		// insert of a present tag keeps the old handle
		send_fields(flca_pkg::FUNC_INSERT, 15, 255, 16'h1234);
		send_fields(flca_pkg::FUNC_LOOKUP, 15, 255, 0);
		send_fields(flca_pkg::FUNC_LOOKUP, 15, 0, 0);
		send_fields(flca_pkg::FUNC_LOOKUP, 0, 255, 0);
	endtask

	task automatic test_tiny_capacity();
		drop_valid();
		wait_drained();
		write_lines(0);   // zero acts as one entry
		send_fields(flca_pkg::FUNC_INSERT, 1, 1, 16'h00aa);
		send_fields(flca_pkg::FUNC_INSERT, 2, 2, 16'h00bb);
		send_fields(flca_pkg::FUNC_LOOKUP, 1, 1, 0);
		send_fields(flca_pkg::FUNC_LOOKUP, 2, 2, 0);
		drop_valid();
		wait_drained();
		write_lines(2);
		send_fields(flca_pkg::FUNC_INSERT, 3, 10, 16'h1111);
		send_fields(flca_pkg::FUNC_INSERT, 4, 20, 16'h2222);
		send_fields(flca_pkg::FUNC_LOOKUP, 3, 10, 0);
		send_fields(flca_pkg::FUNC_INSERT, 5, 30, 16'h3333);   // LRU victim is 4/20
		send_fields(flca_pkg::FUNC_LOOKUP, 4, 20, 0);
		send_fields(flca_pkg::FUNC_LOOKUP, 3, 10, 0);
	endtask

	task automatic test_random_traffic();
		run_traffic(1, 40, 60);
		run_traffic(2, 50, 60);
		run_traffic(3, 50, 60);
		run_traffic(5, 60, 60);
		run_traffic(8, 60, 60);
		run_traffic(16, 70, 60);
		run_traffic(33, 70, 65);
		run_traffic(127, 160, 75);   // saturates to the full row
		run_traffic(0, 30, 60);
	endtask

	task automatic test_backpressure();
		src_calm = 1'b1;
		// empty the block first so the long stall lands on fresh traffic
		drop_valid();
		wait_drained();
		sink_hold = 150;
		run_traffic(4, 30, 60);
		// sender stops until every response is back
		drop_valid();
		wait_drained();
		run_traffic(4, 30, 60);
		src_calm = 1'b0;
	endtask

	task automatic test_full_rate();
		drop_valid();
		wait_drained();
		src_calm  = 1'b1;
		sink_calm = 1'b1;
		run_traffic(64, 150, 70);
	endtask

	initial begin : rsp_sink
		int n;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (sink_hold > 0) begin
				n = sink_hold;
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
				sink_hold = 0;
				rsp_ch.ready <= 1'b1;
			end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		outcome_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("response with nothing pending", rsp_ch.hit, 0);
			end else begin
				e = pending_outcomes.pop_front();
				if (rsp_ch.hit !== e.hit)
					report_mismatch("hit", rsp_ch.hit, e.hit);
				if (rsp_ch.hit_handle !== e.hit_handle)
					report_mismatch("hit_handle", rsp_ch.hit_handle, e.hit_handle);
				if (rsp_ch.evicted !== e.evicted)
					report_mismatch("evicted", rsp_ch.evicted, e.evicted);
				if (rsp_ch.evicted_drum !== e.ev_tag.drum)
					report_mismatch("evicted_drum", rsp_ch.evicted_drum, e.ev_tag.drum);
				if (rsp_ch.evicted_block !== e.ev_tag.block)
					report_mismatch("evicted_block", rsp_ch.evicted_block, e.ev_tag.block);
				if (rsp_ch.evicted_handle !== e.ev_handle)
					report_mismatch("evicted_handle", rsp_ch.evicted_handle, e.ev_handle);
			end
		end
	end

	initial begin
		errors             = 0;
		src_calm           = 1'b0;
		sink_calm          = 1'b0;
		sink_hold          = 0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.func        = flca_pkg::FUNC_LOOKUP;
		req_ch.drum        = '0;
		req_ch.block       = '0;
		req_ch.line_handle = '0;
		clear_image(64);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_tiny_capacity();
		test_random_traffic();
		test_backpressure();
		test_full_rate();

		drop_valid();
		wait_drained();
		repeat (20) @(posedge clk);
		if (pending_outcomes.size() != 0)
			report_mismatch("responses never returned", pending_outcomes.size(), 0);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
